>>> rtl/gne_pkg.sv
// Shared types, codes and offset tables for the grid neighbor enumeration unit.
// No dependencies; used by every module under rtl except gne_queue.
package gne_pkg;

  // Index words and coordinate axes
  localparam int IDX_W    = 24;
  localparam int NUM_AXES = 3;

  // Neighbor entries: the 3-D table is the longest
  localparam int NB_MAX = 26;
  localparam int NB_W   = 5;

  // Divider: quotient bits retired per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = IDX_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Result status codes
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_GRID_SIDE = 1'b0;
  localparam logic CFG_GRID_DIMS = 1'b1;

  // Offset codes along one axis
  typedef logic [1:0] off_t;
  localparam off_t OZ = 2'd0;  // stay
  localparam off_t OP = 2'd1;  // plus one
  localparam off_t OM = 2'd2;  // minus one

  typedef off_t [NUM_AXES-1:0] off_vec_t;

  // 1-D offsets along axis 0
  localparam off_t OFF1 [2] = '{OM, OP};

  // 2-D offsets as (axis 0, axis 1)
  localparam off_t OFF2 [8][2] = '{
    '{OM, OM}, '{OZ, OM}, '{OP, OM}, '{OM, OZ},
    '{OP, OZ}, '{OM, OP}, '{OZ, OP}, '{OP, OP}
  };

  // 3-D offsets as (axis 0, axis 1, axis 2)
  localparam off_t OFF3 [NB_MAX][NUM_AXES] = '{
    '{OM, OZ, OZ}, '{OP, OZ, OZ}, '{OZ, OM, OZ}, '{OZ, OP, OZ},
    '{OM, OM, OZ}, '{OM, OP, OZ}, '{OP, OM, OZ}, '{OP, OP, OZ},
    '{OM, OZ, OM}, '{OP, OZ, OM}, '{OZ, OM, OM}, '{OZ, OP, OM},
    '{OM, OM, OM}, '{OM, OP, OM}, '{OP, OM, OM}, '{OP, OP, OM},
    '{OM, OZ, OP}, '{OP, OZ, OP}, '{OZ, OM, OP}, '{OZ, OP, OP},
    '{OM, OM, OP}, '{OM, OP, OP}, '{OP, OM, OP}, '{OP, OP, OP},
    '{OZ, OZ, OM}, '{OZ, OZ, OP}
  };

  // Number of table entries for a dimension count
  function automatic logic [NB_W-1:0] entry_count(input logic [1:0] dims);
    logic [NB_W-1:0] n;
    case (dims)
      2'd1: n = NB_W'(2);
      2'd2: n = NB_W'(8);
      default: n = NB_W'(NB_MAX);
    endcase
    return n;
  endfunction

  // Offsets of one table entry; unused axes stay put
  function automatic off_vec_t entry_offs(input logic [1:0] dims, input logic [NB_W-1:0] i);
    off_vec_t r;
    r = '{default: OZ};
    case (dims)
      2'd1: begin
        r[0] = OFF1[i[0]];
      end
      2'd2: begin
        r[0] = OFF2[i[2:0]][0];
        r[1] = OFF2[i[2:0]][1];
      end
      default: begin
        if (i < NB_W'(NB_MAX)) begin
          r[0] = OFF3[i][0];
          r[1] = OFF3[i][1];
          r[2] = OFF3[i][2];
        end
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/grid_neighbor_enumeration_unit.sv
// Top level of the grid neighbor enumeration unit: configuration registers,
// front end, queue and back end. Depends on gne_pkg, gne_front, gne_queue, gne_back.
//
// An index word is taken when start is high and busy is low. The front end
// splits it into coordinates with a divider that retires four quotient bits a
// cycle: a 1-D grid or a zero side needs no divider pass, a 2-D grid one pass
// and a 3-D grid two, during which busy is high. A two-entry queue holds
// finished records while the back end emits one result per cycle, one for
// each in-bounds neighbor (up to 26) or a single status word, registered
// through its pipeline stages after the record is picked up. Each result
// is shown for exactly one cycle with result_valid high and must be taken
// then; the unit never waits on the receiver. Write grid_side and grid_dims
// only while idle.
module grid_neighbor_enumeration_unit #(
  parameter int MAX_DIMENSIONS = 3,
  parameter int COORD_BITS     = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [gne_pkg::IDX_W-1:0] region_index,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [7:0]                cfg_data,
  output logic                      result_valid,
  output logic [gne_pkg::IDX_W-1:0] neighbor_index,
  output logic                      is_last,
  output logic [1:0]                status
);
  import gne_pkg::*;

  localparam logic [7:0] SIDE_MAX = 8'((1 << COORD_BITS) - 1);
  localparam int         REC_W    = 2 + NUM_AXES * COORD_BITS;

  logic [7:0]            grid_side;
  logic [1:0]            grid_dims;
  logic [COORD_BITS-1:0] side_eff;
  logic [1:0]            dims_eff;

  logic                                 push;
  logic [1:0]                           push_status;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]  push_coord;
  logic                                 q_full;
  logic                                 q_empty;
  logic                                 pop;
  logic [REC_W-1:0]                     head_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= 8'd16;
      grid_dims <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SIDE: grid_side <= cfg_data;
        CFG_GRID_DIMS: grid_dims <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Clamp side to the coordinate range and dims to the supported count
  assign side_eff = (grid_side > SIDE_MAX) ? SIDE_MAX[COORD_BITS-1:0]
                                           : grid_side[COORD_BITS-1:0];

  always_comb begin
    if (grid_dims == 2'd0) begin
      dims_eff = 2'd1;
    end else if (int'(grid_dims) > MAX_DIMENSIONS) begin
      dims_eff = 2'(MAX_DIMENSIONS);
    end else begin
      dims_eff = grid_dims;
    end
  end

  gne_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .region_index (region_index),
    .side         (side_eff),
    .dims         (dims_eff),
    .q_full       (q_full),
    .busy         (busy),
    .push         (push),
    .push_status  (push_status),
    .push_coord   (push_coord)
  );

  gne_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_status, push_coord}),
    .pop       (pop),
    .head_data (head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  gne_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .side           (side_eff),
    .dims           (dims_eff),
    .q_valid        (!q_empty),
    .head_status    (head_data[REC_W-1 -: 2]),
    .head_coord     (head_data[NUM_AXES*COORD_BITS-1:0]),
    .pop            (pop),
    .result_valid   (result_valid),
    .neighbor_index (neighbor_index),
    .is_last        (is_last),
    .status         (status)
  );

endmodule

>>> rtl/gne_front.sv
// Front end: takes index words, splits them into grid coordinates with an
// iterative divider and checks the range. Depends on gne_pkg.
module gne_front #(
  parameter int COORD_BITS = 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [gne_pkg::IDX_W-1:0]                     region_index,
  input  logic [COORD_BITS-1:0]                         side,
  input  logic [1:0]                                    dims,
  input  logic                                          q_full,
  output logic                                          busy,
  output logic                                          push,
  output logic [1:0]                                    push_status,
  output logic [gne_pkg::NUM_AXES-1:0][COORD_BITS-1:0]  push_coord
);
  import gne_pkg::*;

  localparam int COORD_VEC_W = NUM_AXES * COORD_BITS;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_HOLD = 3'b100
  } front_state_t;

  front_state_t                        state;
  logic [IDX_W-1:0]                    dvd;
  logic [COORD_BITS-1:0]               rem;
  logic [DIV_CNT_W-1:0]                step_cnt;
  logic                                more_pass;
  logic [1:0]                          rec_status;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] rec_coord;

  logic [IDX_W-1:0]      dvd_next;
  logic [COORD_BITS-1:0] rem_next;
  logic [COORD_BITS:0]   trial;
  logic                  ge;
  logic                  accept;

  // Hold off only while dividing or while the record cannot leave
  assign busy   = (state == F_DIV) || ((state == F_HOLD) && q_full);
  assign accept = start && !busy;
  assign push   = (state == F_HOLD) && !q_full;

  assign push_status = rec_status;
  assign push_coord  = rec_coord;

  // Retire DIV_BITS quotient bits by restoring steps
  always_comb begin
    dvd_next = dvd;
    rem_next = rem;
    trial    = '0;
    ge       = 1'b0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial    = {rem_next, dvd_next[IDX_W-1]};
      ge       = (trial >= {1'b0, side});
      dvd_next = {dvd_next[IDX_W-2:0], ge};
      rem_next = ge ? COORD_BITS'(trial - {1'b0, side}) : trial[COORD_BITS-1:0];
    end
  end

  // Sequence: accept, divide once per extra axis, then hand the record over
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      step_cnt  <= '0;
      more_pass <= 1'b0;
    end else if (accept) begin
      if (side == '0) begin
        rec_status <= ST_RANGE;
        rec_coord  <= '0;
        state      <= F_HOLD;
      end else if (dims == 2'd1) begin
        rec_status <= (region_index < IDX_W'(side)) ? ST_VALID : ST_RANGE;
        rec_coord  <= COORD_VEC_W'(region_index[COORD_BITS-1:0]);
        state      <= F_HOLD;
      end else begin
        rec_coord <= '0;
        dvd       <= region_index;
        rem       <= '0;
        step_cnt  <= '0;
        more_pass <= (dims == 2'd3);
        state     <= F_DIV;
      end
    end else if (state == F_HOLD) begin
      if (!q_full) begin
        state <= F_IDLE;
      end
    end else if (state == F_DIV) begin
      dvd <= dvd_next;
      if (step_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        step_cnt <= '0;
        rem      <= '0;
        if (more_pass) begin
          // Least significant axis of a 3-D grid; divide the quotient again
          rec_coord[2] <= rem_next;
          more_pass    <= 1'b0;
        end else begin
          rec_coord[1] <= rem_next;
          rec_coord[0] <= dvd_next[COORD_BITS-1:0];
          rec_status   <= (dvd_next < IDX_W'(side)) ? ST_VALID : ST_RANGE;
          state        <= F_HOLD;
        end
      end else begin
        step_cnt <= step_cnt + 1'b1;
        rem      <= rem_next;
      end
    end
  end

endmodule

>>> rtl/gne_queue.sv
// Small register queue that decouples front and back.
// Generic in width and depth; no package dependencies.
module gne_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign head_data = slots[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/gne_back.sv
// Back end: walks the in-bounds neighbor mask of one record, one neighbor a
// cycle, and rebuilds linear indices in a two-multiply pipeline. Depends on gne_pkg.
module gne_back #(
  parameter int COORD_BITS = 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [COORD_BITS-1:0]                         side,
  input  logic [1:0]                                    dims,
  input  logic                                          q_valid,
  input  logic [1:0]                                    head_status,
  input  logic [gne_pkg::NUM_AXES-1:0][COORD_BITS-1:0]  head_coord,
  output logic                                          pop,
  output logic                                          result_valid,
  output logic [gne_pkg::IDX_W-1:0]                     neighbor_index,
  output logic                                          is_last,
  output logic [1:0]                                    status
);
  import gne_pkg::*;

  localparam int AW = 2 * COORD_BITS;

  typedef logic [NUM_AXES-1:0][COORD_BITS-1:0] coord_vec_t;

  // Record being walked
  logic              cur_valid;
  logic              cur_single;
  logic [1:0]        cur_status;
  logic [NB_MAX-1:0] cur_mask;
  coord_vec_t        cur_coord;

  // Pipeline stages
  logic                  p1_valid;
  logic                  p1_last;
  logic [1:0]            p1_status;
  coord_vec_t            p1_v;
  logic                  p2_valid;
  logic                  p2_last;
  logic [1:0]            p2_status;
  logic [AW-1:0]         p2_a;
  logic [COORD_BITS-1:0] p2_tail;

  logic [NB_MAX-1:0]     head_mask;
  logic [NUM_AXES-1:0]   lo;
  logic [NUM_AXES-1:0]   hi;
  logic [NB_MAX-1:0]     low_bit;
  logic [NB_MAX-1:0]     rest_mask;
  logic [NB_W-1:0]       sel;
  off_vec_t              sel_offs;
  off_vec_t              chk_offs;
  coord_vec_t            step_v;
  logic                  cur_done;
  logic                  ok;

  // Flag coordinates that sit on a grid edge
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      lo[a] = (head_coord[a] == '0);
      hi[a] = (head_coord[a] == side - COORD_BITS'(1));
    end
  end

  // Mark every table entry that stays inside the grid
  always_comb begin
    head_mask = '0;
    chk_offs  = '{default: OZ};
    ok        = 1'b0;
    for (int i = 0; i < NB_MAX; i++) begin
      chk_offs = entry_offs(dims, NB_W'(i));
      ok       = (NB_W'(i) < entry_count(dims));
      for (int a = 0; a < NUM_AXES; a++) begin
        if ((chk_offs[a] == OM && lo[a]) || (chk_offs[a] == OP && hi[a])) begin
          ok = 1'b0;
        end
      end
      head_mask[i] = ok;
    end
  end

  // Pick the lowest pending entry
  assign low_bit   = cur_mask & (~cur_mask + NB_MAX'(1));
  assign rest_mask = cur_mask & ~low_bit;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NB_MAX; i++) begin
      if (low_bit[i]) begin
        sel = sel | NB_W'(i);
      end
    end
  end

  assign sel_offs = entry_offs(dims, sel);

  // Step each coordinate by its offset
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      case (sel_offs[a])
        OP:      step_v[a] = cur_coord[a] + COORD_BITS'(1);
        OM:      step_v[a] = cur_coord[a] - COORD_BITS'(1);
        default: step_v[a] = cur_coord[a];
      endcase
    end
  end

  assign cur_done = cur_valid && (cur_single || (rest_mask == '0));
  assign pop      = q_valid && (!cur_valid || cur_done);

  // Load a new record or drop the entry just issued
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid  <= 1'b1;
      cur_mask   <= head_mask;
      cur_coord  <= head_coord;
      cur_single <= (head_status != ST_VALID) || (head_mask == '0);
      if (head_status != ST_VALID) begin
        cur_status <= head_status;
      end else begin
        cur_status <= (head_mask == '0) ? ST_NONE : ST_VALID;
      end
    end else if (cur_done) begin
      cur_valid <= 1'b0;
    end else if (cur_valid) begin
      cur_mask <= rest_mask;
    end
  end

  // Stage 1: neighbor coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= cur_valid;
    end
    p1_last   <= cur_single || (rest_mask == '0);
    p1_status <= cur_status;
    p1_v      <= cur_single ? '0 : step_v;
  end

  // Stage 2: fold the two leading axes of a 3-D grid, else pass axes 0 and 1 on
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_last   <= p1_last;
    p2_status <= p1_status;
    if (dims == 2'd3) begin
      p2_a    <= AW'(p1_v[0]) * AW'(side) + AW'(p1_v[1]);
      p2_tail <= p1_v[2];
    end else begin
      p2_a    <= AW'(p1_v[0]);
      p2_tail <= p1_v[1];
    end
  end

  // Stage 3: final fold into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= p2_valid;
    end
    is_last <= p2_last;
    status  <= p2_status;
    if (dims == 2'd1) begin
      neighbor_index <= IDX_W'(p2_a);
    end else begin
      neighbor_index <= IDX_W'(p2_a) * IDX_W'(side) + IDX_W'(p2_tail);
    end
  end

endmodule
